// ----- rtl/gdate_pkg.sv -----
// constants and helpers for the gregorian date plus day offset pipeline
package gdate_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // field widths
    localparam int OFFSET_W    = 28;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_IN_W   = 14;
    localparam int YEAR_OUT_W  = 20;

    // input field positions in tdata
    localparam int OFFSET_LSB  = 0;
    localparam int DAY_LSB     = OFFSET_LSB + OFFSET_W;
    localparam int MONTH_LSB   = DAY_LSB + DAY_W;
    localparam int YEAR_LSB    = MONTH_LSB + MONTH_W;
    localparam int IN_USED_W   = YEAR_LSB + YEAR_IN_W;

    // output field positions in tdata
    localparam int ODAY_LSB    = 0;
    localparam int OMONTH_LSB  = ODAY_LSB + DAY_W;
    localparam int OYEAR_LSB   = OMONTH_LSB + MONTH_W;
    localparam int OUT_USED_W  = OYEAR_LSB + YEAR_OUT_W;

    // calendar constants
    localparam int DAYS_PER_YEAR  = 365;
    localparam int YEARS_PER_CYC  = 400;
    localparam int DAYS_PER_CYC   = 146097;

    // year estimate (10000*g + 14780) / 3652425, all three scaled down by five
    localparam int EST_MUL   = 2000;
    localparam int EST_BIAS  = 2956;
    localparam int EST_DEN   = 730485;

    // month index estimate (100*doy + 52) / 3060
    localparam int MI_MUL    = 100;
    localparam int MI_BIAS   = 52;
    localparam int MI_DEN    = 3060;

    // reciprocal shifts, each checked against the largest numerator in its path
    localparam int Y100_SHIFT = 21;
    localparam int CYC_SHIFT  = 47;
    localparam int EST_SHIFT  = 49;
    localparam int MI_SHIFT   = 28;

    localparam logic [14:0] RECIP_Y100 =
        15'(((64'd1 << Y100_SHIFT) + 64'd99) / 64'd100);
    localparam logic [29:0] RECIP_CYC =
        30'(((64'd1 << CYC_SHIFT) + 64'(DAYS_PER_CYC) - 64'd1) / 64'(DAYS_PER_CYC));
    localparam logic [29:0] RECIP_EST =
        30'(((64'd1 << EST_SHIFT) + 64'(EST_DEN) - 64'd1) / 64'(EST_DEN));
    localparam logic [16:0] RECIP_MI =
        17'(((64'd1 << MI_SHIFT) + 64'(MI_DEN) - 64'd1) / 64'(MI_DEN));

    // first day of each march-based month, (m*306 + 5) / 10
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gregorian_date_add_days.sv -----
// gregorian date plus day offset, ten stage pipeline
//
// usage:
//   s_axis carries one request per beat: a start date (day, month, year) and
//   a day offset. m_axis returns the resulting date, one result per request,
//   in request order. no configuration, no state kept between requests.
//   the pipeline has ten register stages.
//   throughput: one request per cycle, sustained while m_axis_tready is high.
//   the stages are: month fold and year/100 reciprocal, day number sum,
//   400-year cycle reciprocal, cycle start, cycle remainder scaling, year
//   estimate reciprocal, day-of-year, year correction, month reciprocal,
//   output formatting.
//   reset clears every stage valid bit; payload registers are not reset.
//   when m_axis_tready is low the output holds; the stages behind it keep
//   advancing until they fill, so s_axis_tready stays high while any stage
//   holds a bubble and drops only when all ten stages are full.
//   dates are not checked; bad days and months run through the same math.
//   a result year before zero comes out as 20-bit two's complement.
module gregorian_date_add_days
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // day_offset[27:0], in_day[32:28], in_month[36:33], in_year[50:37], zero[55:51]
    input  logic [gdate_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_day[4:0], out_month[8:5], out_year[28:9], zero[31:29]
    output logic [gdate_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import gdate_pkg::*;

    localparam int NSTAGE = 10;

    // stage valid bits and per-stage advance
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    // stage 0: shifted year, year/100 product, month start + day - 1, offset
    logic [YEAR_IN_W-1:0]    y0_reg;
    logic                    yneg0_reg;
    logic [28:0]             prod0_reg;
    logic signed [9:0]       msd0_reg;
    logic [OFFSET_W-1:0]     ofs0_reg;

    // stage 1: day number
    logic signed [29:0]      g1_reg;

    // stage 2: 400-year cycle reciprocal product
    logic signed [29:0]      g2_reg;
    logic [57:0]             prod2_reg;

    // stage 3: cycle count and cycle start day
    logic signed [29:0]      g3_reg;
    logic [10:0]             q43_reg;
    logic [28:0]             p3_reg;

    // stage 4: remainder in cycle and scaled estimate numerator
    logic signed [18:0]      r4s4_reg;
    logic [28:0]             n4_reg;
    logic [10:0]             q44_reg;

    // stage 5: year-in-cycle reciprocal product
    logic signed [18:0]      r4s5_reg;
    logic [10:0]             q45_reg;
    logic [57:0]             prod5_reg;

    // stage 6: raw day of year
    logic signed [18:0]      doya6_reg;
    logic [8:0]              k6_reg;
    logic [10:0]             q46_reg;

    // stage 7: corrected day of year and year
    logic [8:0]              doy7_reg;
    logic [YEAR_OUT_W-1:0]   yr7_reg;

    // stage 8: month index reciprocal product
    logic [31:0]             prod8_reg;
    logic [8:0]              doy8_reg;
    logic [YEAR_OUT_W-1:0]   yr8_reg;

    // stage 9: output
    logic [DAY_W-1:0]        day9_reg;
    logic [MONTH_W-1:0]      month9_reg;
    logic [YEAR_OUT_W-1:0]   year9_reg;

    // next values
    logic [4:0]              msum;
    logic [3:0]              mm_next;
    logic                    ydec;
    logic [YEAR_IN_W-1:0]    y0_next;
    logic                    yneg0_next;
    logic [28:0]             prod0_next;
    logic signed [9:0]       msd0_next;

    logic [7:0]              q100;
    logic [22:0]             dby_u;
    logic signed [29:0]      dby_s;
    logic signed [29:0]      g1_next;

    logic [28:0]             gpos;
    logic [57:0]             prod2_next;

    logic [10:0]             q43_next;
    logic [28:0]             p3_next;

    logic signed [29:0]      r4_full;
    logic signed [18:0]      r4s4_next;
    logic [17:0]             r4pos;
    logic [28:0]             n4_next;

    logic [57:0]             prod5_next;

    logic [8:0]              kk;
    logic [2:0]              c100;
    logic [17:0]             dbyk;
    logic signed [18:0]      doya6_next;

    logic                    back;
    logic                    leap;
    logic [8:0]              ylen;
    logic signed [18:0]      doy_sum;
    logic [8:0]              doy7_next;
    logic [YEAR_OUT_W-1:0]   yr7_next;

    logic [15:0]             n2;
    logic [31:0]             prod8_next;

    logic [3:0]              mi;
    logic                    wrap;
    logic [8:0]              dfull;
    logic [MONTH_W-1:0]      month9_next;
    logic [YEAR_OUT_W-1:0]   year9_next;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                            year9_reg, month9_reg, day9_reg};

    // stage 0: fold month to march base, year/100 by reciprocal
    always_comb
    begin
        msum = 5'(s_axis_tdata[MONTH_LSB +: MONTH_W]) + 5'd9;
        if (msum >= 5'd24)
        begin
            mm_next = 4'(msum - 5'd24);
        end
        else if (msum >= 5'd12)
        begin
            mm_next = 4'(msum - 5'd12);
        end
        else
        begin
            mm_next = msum[3:0];
        end
        // january and february belong to the previous march-based year
        ydec       = (mm_next >= 4'd10);
        y0_next    = s_axis_tdata[YEAR_LSB +: YEAR_IN_W] - YEAR_IN_W'(ydec);
        yneg0_next = ydec && (s_axis_tdata[YEAR_LSB +: YEAR_IN_W] == '0);
        prod0_next = 29'(y0_next) * 29'(RECIP_Y100);
        msd0_next  = $signed({1'b0, month_start(mm_next)})
                   + $signed(10'(s_axis_tdata[DAY_LSB +: DAY_W])) - 10'sd1;
    end

    // stage 1: day number from the march-based epoch plus offset
    always_comb
    begin
        q100  = prod0_reg[28:21];
        dby_u = 23'(y0_reg) * 23'(DAYS_PER_YEAR) + 23'(y0_reg[13:2])
              - 23'(q100) + 23'(q100[7:2]);
        // year -1 truncates every quotient to zero
        dby_s = yneg0_reg ? -30'sd365 : $signed({7'd0, dby_u});
        g1_next = dby_s + {{20{msd0_reg[9]}}, msd0_reg}
                + $signed({2'b00, ofs0_reg});
    end

    // stage 2: cycle reciprocal; a negative day number estimates year zero
    always_comb
    begin
        gpos       = g1_reg[29] ? 29'd0 : g1_reg[28:0];
        prod2_next = 58'(gpos) * 58'(RECIP_CYC);
    end

    // stage 3: cycle count and first day of that cycle
    always_comb
    begin
        q43_next = prod2_reg[57:47];
        p3_next  = 29'(q43_next) * 29'(DAYS_PER_CYC);
    end

    // stage 4: day within the cycle and year estimate numerator
    always_comb
    begin
        r4_full   = g3_reg - $signed({1'b0, p3_reg});
        r4s4_next = r4_full[18:0];
        r4pos     = r4s4_next[18] ? 18'd0 : r4s4_next[17:0];
        n4_next   = 29'(r4pos) * 29'(EST_MUL) + 29'(EST_BIAS);
    end

    // stage 5: year within the cycle by reciprocal
    assign prod5_next = 58'(n4_reg) * 58'(RECIP_EST);

    // stage 6: days before the estimated year inside the cycle
    always_comb
    begin
        kk   = prod5_reg[57:49];
        c100 = 3'(kk >= 9'd100) + 3'(kk >= 9'd200) + 3'(kk >= 9'd300)
             + 3'(kk >= 9'd400);
        dbyk = 18'(kk) * 18'(DAYS_PER_YEAR) + 18'(kk[8:2]) - 18'(c100)
             + 18'(kk >= 9'(YEARS_PER_CYC));
        doya6_next = r4s5_reg - $signed({1'b0, dbyk});
    end

    // stage 7: step the year back once when the day of year went negative
    always_comb
    begin
        back = doya6_reg[18];
        leap = (k6_reg[1:0] == 2'b00)
            && !((k6_reg == 9'd100) || (k6_reg == 9'd200) || (k6_reg == 9'd300));
        // year 0 minus one truncates to a plain 365-day year
        if ((q46_reg == '0) && (k6_reg == '0))
        begin
            ylen = 9'(DAYS_PER_YEAR);
        end
        else
        begin
            ylen = 9'(DAYS_PER_YEAR) + 9'(leap);
        end
        doy_sum   = doya6_reg + $signed({10'd0, ylen});
        doy7_next = back ? doy_sum[8:0] : doya6_reg[8:0];
        yr7_next  = 20'(q46_reg) * 20'(YEARS_PER_CYC) + 20'(k6_reg) - 20'(back);
    end

    // stage 8: month index by reciprocal
    always_comb
    begin
        n2         = 16'(doy7_reg) * 16'(MI_MUL) + 16'(MI_BIAS);
        prod8_next = 32'(n2) * 32'(RECIP_MI);
    end

    // stage 9: back to january-based month, carry into the year
    always_comb
    begin
        mi          = prod8_reg[31:28];
        wrap        = (mi >= 4'd10);
        month9_next = wrap ? 4'(mi - 4'd9) : 4'(mi + 4'd3);
        year9_next  = yr8_reg + 20'(wrap);
        dfull       = doy8_reg - month_start(mi) + 9'd1;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            y0_reg    <= y0_next;
            yneg0_reg <= yneg0_next;
            prod0_reg <= prod0_next;
            msd0_reg  <= msd0_next;
            ofs0_reg  <= s_axis_tdata[OFFSET_LSB +: OFFSET_W];
        end
        if (adv[1])
        begin
            g1_reg <= g1_next;
        end
        if (adv[2])
        begin
            g2_reg    <= g1_reg;
            prod2_reg <= prod2_next;
        end
        if (adv[3])
        begin
            g3_reg  <= g2_reg;
            q43_reg <= q43_next;
            p3_reg  <= p3_next;
        end
        if (adv[4])
        begin
            r4s4_reg <= r4s4_next;
            n4_reg   <= n4_next;
            q44_reg  <= q43_reg;
        end
        if (adv[5])
        begin
            r4s5_reg  <= r4s4_reg;
            q45_reg   <= q44_reg;
            prod5_reg <= prod5_next;
        end
        if (adv[6])
        begin
            doya6_reg <= doya6_next;
            k6_reg    <= kk;
            q46_reg   <= q45_reg;
        end
        if (adv[7])
        begin
            doy7_reg <= doy7_next;
            yr7_reg  <= yr7_next;
        end
        if (adv[8])
        begin
            prod8_reg <= prod8_next;
            doy8_reg  <= doy7_reg;
            yr8_reg   <= yr7_reg;
        end
        if (adv[9])
        begin
            day9_reg   <= dfull[4:0];
            month9_reg <= month9_next;
            year9_reg  <= year9_next;
        end
    end

endmodule
